// ===== design/isb_pkg.sv =====
// ----------------------------------------------------------------------------
// isb_pkg
// Shared field widths and item kind codes for the interrupt slot balancer.
// ----------------------------------------------------------------------------
package isb_pkg;

	localparam int INTERVAL_W = 16;
	localparam int SLOT_W     = 7;

	// item kinds carried in tuser on the input side
	localparam logic KIND_OPEN  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	localparam int IN_DATA_W  = ((INTERVAL_W + SLOT_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SLOT_W + 7) / 8) * 8;

endpackage

// ===== design/interrupt_slot_balancer.sv =====
// ----------------------------------------------------------------------------
// interrupt_slot_balancer
// Per-slot load counters for an interrupt schedule tree. An open beat picks
// the least loaded slot of its polling level and counts it up, a close beat
// counts the named slot down. Counters saturate and flag an error.
// ----------------------------------------------------------------------------
// Open: the p slots of one polling level (p = scanned level size, at most
// SLOTS/2) are read through the counter RAM read port into one load
// comparator, then ST_DRAIN and ST_UPD follow. Close, or open with interval
// zero: at most one slot is scanned. One beat in work at a time; a finished
// result may wait in the output register while the next is taken. After
// reset the counter RAM is cleared one entry a cycle, with s_tready low.
// ----------------------------------------------------------------------------
module interrupt_slot_balancer
	import isb_pkg::*;
#(
	parameter int SLOTS      = 128,
	parameter int LOAD_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // interval[15:0], release_slot[22:16], zero fill
	input  logic                  s_tuser,  // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // chosen_slot[6:0], zero fill
	output logic                  m_tuser   // load_error
);

	localparam int SW = $clog2(SLOTS);

	function automatic int top_level_f();
		int p;
		p = 1;
		while ((p * 2) <= (SLOTS / 2))
			p = p * 2;
		return p;
	endfunction

	localparam int TOP = top_level_f();
	localparam logic [SW-1:0] TOP_IDX  = SW'(TOP);
	localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
	localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = {LOAD_WIDTH{1'b1}};

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;

	logic [2:0]            state_q;
	logic [SW-1:0]         addr_q;
	logic [SW-1:0]         last_q;
	logic                  kind_q;
	logic                  bad_q;
	logic [SLOT_W-1:0]     rel_q;
	logic                  first_q;
	logic                  rd_vld_s1;
	logic [SW-1:0]         rd_idx_s1;
	logic [LOAD_WIDTH-1:0] rdata_q;
	logic [LOAD_WIDTH-1:0] best_load_q;
	logic [SW-1:0]         best_idx_q;
	logic                  out_vld_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic                  out_err_q;

	logic [INTERVAL_W-1:0] in_interval;
	logic [SLOT_W-1:0]     in_rel;
	logic                  accept;
	logic                  out_free;
	logic [SW-1:0]         level;
	logic                  rel_bad;

	logic                  we;
	logic [SW-1:0]         waddr;
	logic [LOAD_WIDTH-1:0] wdata;
	logic                  upd_err;

	logic [LOAD_WIDTH-1:0] mem [SLOTS];

	assign in_interval = s_tdata[INTERVAL_W-1:0];
	assign in_rel      = s_tdata[INTERVAL_W+SLOT_W-1:INTERVAL_W];
	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign out_free    = !out_vld_q || m_tready;
	assign rel_bad     = (32'(in_rel) >= 32'(SLOTS));

	// largest power of two not above min(interval, TOP); zero for interval zero
	always_comb begin
		level = '0;
		if (32'(in_interval) >= 32'(TOP)) begin
			level = TOP_IDX;
		end else begin
			for (int i = 0; i < SW; i++) begin
				if (in_interval[i])
					level = SW'(1) << i;
			end
		end
	end

	always_comb begin
		we      = 1'b0;
		waddr   = best_idx_q;
		wdata   = best_load_q;
		upd_err = 1'b0;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = addr_q;
			wdata = '0;
		end else if (state_q == ST_UPD) begin
			if (bad_q) begin
				upd_err = 1'b1;
			end else if (kind_q == KIND_OPEN) begin
				if (best_load_q == LOAD_MAX)
					upd_err = 1'b1;
				else
					wdata = best_load_q + 1'b1;
			end else begin
				if (best_load_q == '0)
					upd_err = 1'b1;
				else
					wdata = best_load_q - 1'b1;
			end
			we = out_free && !upd_err;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[addr_q];
	end

	// first strictly smaller load wins, so ties keep the lowest slot
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (first_q || (rdata_q < best_load_q))) begin
			best_load_q <= rdata_q;
			best_idx_q  <= rd_idx_s1;
		end
		rd_idx_s1 <= addr_q;
		if (state_q == ST_UPD && out_free) begin
			out_slot_q <= (kind_q == KIND_OPEN) ? SLOT_W'(best_idx_q) : rel_q;
			out_err_q  <= upd_err;
		end
		if (accept) begin
			kind_q <= s_tuser;
			rel_q  <= in_rel;
			bad_q  <= (s_tuser == KIND_CLOSE) && rel_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			addr_q    <= '0;
			last_q    <= '0;
			first_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (rd_vld_s1)
				first_q <= 1'b0;
			if (state_q == ST_UPD && out_free)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_IDX)
						state_q <= ST_IDLE;
					else
						addr_q <= addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						first_q <= 1'b1;
						if (s_tuser == KIND_CLOSE) begin
							addr_q  <= SW'(in_rel);
							last_q  <= SW'(in_rel);
							state_q <= rel_bad ? ST_UPD : ST_SCAN;
						end else if (level == '0) begin
							addr_q  <= '0;
							last_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							addr_q  <= level;
							last_q  <= level + (level - 1'b1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (addr_q == last_q)
						state_q <= ST_DRAIN;
					else
						addr_q <= addr_q + 1'b1;
				end
				ST_DRAIN: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'(out_slot_q);
	assign m_tuser  = out_err_q;

endmodule

// ===== test/tb_interrupt_slot_balancer.sv =====
// ----------------------------------------------------------------------------
// tb_interrupt_slot_balancer
// Self-checking bench for the interrupt slot balancer. A short table of open
// and close beats comes first, then random open/close traffic with random
// gaps on both sides.
// Every result beat is checked against a local model of the slot loads, or against the table's fixed value.
// ----------------------------------------------------------------------------
module tb_interrupt_slot_balancer;
	import isb_pkg::*;

	localparam int SLOTS        = 128;
	localparam int LOAD_WIDTH   = 16;
	localparam int LOAD_MAX     = (1 << LOAD_WIDTH) - 1;
	localparam int RANDOM_BEATS = 1250;
	localparam int MAX_WAIT     = 13;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              err;
	} grant_t;

	typedef struct {
		logic                  kind;
		logic [INTERVAL_W-1:0] interval;
		logic [SLOT_W-1:0]     rel;
		bit                    typed;
		grant_t                want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = KIND_OPEN;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	int     load_count[SLOTS];
	grant_t pending_grants[$];
	int     mismatches  = 0;
	int     idle_cycles = 0;
	bit     steady      = 1'b0;

	interrupt_slot_balancer #(
		.SLOTS      (SLOTS),
		.LOAD_WIDTH (LOAD_WIDTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		foreach (load_count[i])
			load_count[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// updates the slot loads for one accepted beat and returns the grant
	function automatic grant_t allocate_or_release(logic kind, logic [INTERVAL_W-1:0] interval,
			logic [SLOT_W-1:0] rel);
		grant_t g;
		int     p;
		int     best;
		g.err = 1'b0;
		if (kind == KIND_OPEN) begin
			p = 1;
			while ((p << 1) <= SLOTS / 2)
				p = p << 1;
			while (p != 0 && int'(interval) < p)
				p = p >> 1;
			best = 0;
			if (p != 0) begin
				best = p;
				// first slot with the least load wins
				for (int s = p + 1; s < 2 * p && s < SLOTS; s++)
					if (load_count[s] < load_count[best])
						best = s;
			end
			if (load_count[best] >= LOAD_MAX) begin
				load_count[best] = LOAD_MAX;
				g.err = 1'b1;
			end else begin
				load_count[best]++;
			end
			g.slot = best[SLOT_W-1:0];
		end else begin
			g.slot = rel;
			if (int'(rel) >= SLOTS || load_count[rel] == 0)
				g.err = 1'b1;
			else
				load_count[rel]--;
		end
		return g;
	endfunction

	function automatic void flag_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
	endfunction

	task automatic send_beat(input logic kind, input logic [INTERVAL_W-1:0] interval,
			input logic [SLOT_W-1:0] rel, output grant_t g);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_DATA_W'({rel, interval});
		do @(posedge clk); while (!s_tready);
		g = allocate_or_release(kind, interval, rel);
	endtask

	// result side
	initial begin : receive
		int     stall;
		grant_t want;
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_grants.size() == 0) begin
				flag_mismatch("beat with nothing outstanding, slot", -1,
					int'(m_tdata[SLOT_W-1:0]));
			end else begin
				want = pending_grants.pop_front();
				if (m_tdata[SLOT_W-1:0] !== want.slot)
					flag_mismatch("chosen_slot", int'(want.slot), int'(m_tdata[SLOT_W-1:0]));
				if (m_tuser !== want.err)
					flag_mismatch("load_error", int'(want.err), int'(m_tuser));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("interrupt_slot_balancer regression: fail");
			$finish;
		end
	end

	initial begin : drive
		stim_row_t             directed_rows[24];
		grant_t                g;
		int                    slot_pool[$];
		int                    pick;
		int                    roll;
		int                    lvl;
		logic [INTERVAL_W-1:0] ivl;
		logic [SLOT_W-1:0]     rel;

		directed_rows = '{
			'{KIND_CLOSE, 16'h0000, 7'd5,   1'b1, '{7'd5,   1'b1}},  // close on an empty slot
			'{KIND_OPEN,  16'h0000, 7'h7f,  1'b1, '{7'd0,   1'b0}},  // interval zero
			'{KIND_OPEN,  16'h0001, 7'd0,   1'b1, '{7'd1,   1'b0}},
			'{KIND_OPEN,  16'hffff, 7'd0,   1'b1, '{7'd64,  1'b0}},
			'{KIND_CLOSE, 16'hffff, 7'd127, 1'b1, '{7'd127, 1'b1}},
			'{KIND_OPEN,  16'hffff, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h0002, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h0003, 7'd0,   1'b0, '{7'd0,   1'b0}},  // less loaded slot wins
			'{KIND_OPEN,  16'h0003, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h0040, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h007f, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h0064, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h003f, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h0004, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_CLOSE, 16'h0000, 7'd64,  1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'hffff, 7'd0,   1'b0, '{7'd0,   1'b0}},  // freed slot is least loaded
			'{KIND_CLOSE, 16'h5555, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_CLOSE, 16'h0000, 7'd0,   1'b0, '{7'd0,   1'b0}},  // underflow
			'{KIND_OPEN,  16'h8000, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h0100, 7'd0,   1'b0, '{7'd0,   1'b0}},
			'{KIND_CLOSE, 16'h0000, 7'd1,   1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'h5555, 7'h2a,  1'b0, '{7'd0,   1'b0}},
			'{KIND_OPEN,  16'haaaa, 7'h55,  1'b0, '{7'd0,   1'b0}},
			'{KIND_CLOSE, 16'haaaa, 7'd64,  1'b0, '{7'd0,   1'b0}}
		};

		wait (arst_n);
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].kind, directed_rows[i].interval, directed_rows[i].rel, g);
			pending_grants.push_back(directed_rows[i].typed ? directed_rows[i].want : g);
		end

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				roll = $urandom_range(0, 9);
				if (roll == 0) begin
					ivl = '0;
				end else if (roll == 1) begin
					ivl = INTERVAL_W'($urandom_range(0, 65535));
				end else begin
					// mostly short levels, the wide scans are slow
					lvl = $urandom_range(0, 6);
					ivl = INTERVAL_W'((1 << lvl) + $urandom_range(0, (1 << lvl) - 1));
				end
				send_beat(KIND_OPEN, ivl, SLOT_W'($urandom_range(0, 127)), g);
				if (!g.err)
					slot_pool.push_back(int'(g.slot));
			end else if (roll < 90 && slot_pool.size() != 0) begin
				pick = $urandom_range(0, slot_pool.size() - 1);
				rel  = SLOT_W'(slot_pool[pick]);
				slot_pool.delete(pick);
				send_beat(KIND_CLOSE, INTERVAL_W'($urandom_range(0, 65535)), rel, g);
			end else begin
				send_beat(KIND_CLOSE, INTERVAL_W'($urandom_range(0, 65535)),
					SLOT_W'($urandom_range(0, 127)), g);
			end
			pending_grants.push_back(g);
		end
		s_tvalid <= 1'b0;

		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_grants.size() == 0)
			$display("interrupt_slot_balancer regression: pass");
		else
			$display("interrupt_slot_balancer regression: fail");
		$finish;
	end

endmodule
